>>> hw/rtl/lzo1x_stream_decompressor_defines.svh
// Assertion macros for the LZO1X stream decompressor.
`ifndef LZO1X_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZO1X_STREAM_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTH
`define LZ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LZ_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LZ_ASSERT_IMP(label, clk, rst_n, a, c)
`define LZ_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hw/rtl/lzo_pkg.sv
// Package with shared types and constants of the LZO1X stream decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzo_pkg;
	localparam int WindowBits = 16;
	localparam int LenBits = 24;
	localparam logic [LenBits-1:0] LenMax = '1;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0,
		ST_OK = 3'd1,
		ST_TRAIL = 3'd2,
		ST_NOEND = 3'd3,
		ST_REFUSED = 3'd4,
		ST_OVF = 3'd5
	} status_t;

	typedef enum logic [14:0] {
		PH_FIRST = 15'h0001,
		PH_TOK0 = 15'h0002,
		PH_TOK1 = 15'h0004,
		PH_TOK2 = 15'h0008,
		PH_LITX = 15'h0010,
		PH_LITRUN = 15'h0020,
		PH_PIGGY = 15'h0040,
		PH_M3X = 15'h0080,
		PH_M4X = 15'h0100,
		PH_LO = 15'h0200,
		PH_HI = 15'h0400,
		PH_M2B = 15'h0800,
		PH_M1FAR = 15'h1000,
		PH_M1NEAR = 15'h2000,
		PH_DRAIN = 15'h4000
	} phase_t;

	typedef struct packed {
		logic copy;
		logic [WindowBits-1:0] rd_addr;
		logic emit;
		logic [7:0] lit;
		logic pending;
		status_t status;
	} job_t;
endpackage
`default_nettype wire

>>> hw/rtl/lzo1x_stream_decompressor.sv
// LZO1X stream decompressor top level.
// Each input transfer carries a compressed byte or a request to drain one pending match
// byte, and each gives exactly one result transfer. The parser decodes an item in the cycle
// it is accepted, and the writer holds it for two register stages around the 64 KiB history
// RAM (one read, one write port), forwarding the byte written in the same cycle when a copy
// reads it back at once, so a result is offered once the item has passed both stages. Items can
// follow back to back; the input stalls only while both writer stages are full and res_ready
// is low.
`timescale 1ns / 1ps
`default_nettype none
`include "lzo1x_stream_decompressor_defines.svh"
module lzo1x_stream_decompressor (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic mode,
	input wire logic [7:0] in_byte,
	input wire logic last_byte,
	output logic res_valid,
	input wire logic res_ready,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic copy_pending,
	output logic [2:0] status,
	output logic [31:0] total_out
);
	logic jv, jr;
	lzo_pkg::job_t job;

	lzo_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.mode(mode), .in_byte(in_byte), .last_byte(last_byte),
		.job_valid(jv), .job_ready(jr), .job(job)
	);

	lzo_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(jv), .job_ready(jr), .job(job),
		.res_valid(res_valid), .res_ready(res_ready), .out_byte(out_byte),
		.out_valid(out_valid), .copy_pending(copy_pending), .status(status),
		.total_out(total_out)
	);

	`LZ_ASSERT_IMP(a_nobyte, clk, arst_n, res_valid && !out_valid, out_byte == 8'd0)
	`LZ_ASSERT_IMP(a_status, clk, arst_n, res_valid, status <= 3'd5)
	`LZ_ASSERT_NXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid)
endmodule
`default_nettype wire

>>> hw/rtl/lzo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lzo_ram #(
	parameter int Width = 8,
	parameter int Depth = 65536
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/lzo_front.sv
// Token parser: accepts items, tracks parse state and issues byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module lzo_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	input wire logic mode,
	input wire logic [7:0] in_byte,
	input wire logic last_byte,
	output logic job_valid,
	input wire logic job_ready,
	output lzo_pkg::job_t job
);
	localparam int LB = lzo_pkg::LenBits;
	localparam int WB = lzo_pkg::WindowBits;

	lzo_pkg::phase_t phase_q, ph_n;
	logic [7:0] tok_q, b1_q;
	logic [LB-1:0] acc_q, lit_q, copy_q, acc_n, lit_n, copy_n;
	logic [WB-1:0] dist_q, dist_n, wpos_q;
	logic fin_q, fin_n;
	logic refuse, ovf, eof, emit;
	logic [LB:0] total, accp;
	logic [LB:0] base;
	logic [16:0] off, d;
	lzo_pkg::status_t st;

	assign ready = job_ready;
	assign job_valid = valid;

	always_comb begin
		ph_n = phase_q;
		acc_n = acc_q;
		lit_n = lit_q;
		copy_n = copy_q;
		dist_n = dist_q;
		fin_n = fin_q;
		ovf = 1'b0;
		eof = 1'b0;
		emit = 1'b0;
		st = lzo_pkg::ST_RUN;
		refuse = fin_q || (!mode && copy_q != '0) || (mode && copy_q == '0);
		base = (phase_q == lzo_pkg::PH_LITX) ? (LB+1)'(18) :
			(phase_q == lzo_pkg::PH_M3X) ? (LB+1)'(33) : (LB+1)'(9);
		total = base + {1'b0, acc_q} + (LB+1)'(in_byte);
		accp = {1'b0, acc_q} + (LB+1)'(255);
		off = 17'(b1_q >> 2) + {3'd0, in_byte, 6'd0};
		d = {2'd0, tok_q[3], 14'd0} + off;
		if (refuse) begin
			st = lzo_pkg::ST_REFUSED;
		end else if (mode) begin
			emit = 1'b1;
			copy_n = copy_q - LB'(1);
			if (copy_q == LB'(1)) ph_n = (lit_q != '0) ? lzo_pkg::PH_PIGGY : lzo_pkg::PH_TOK0;
		end else begin
			case (phase_q)
				lzo_pkg::PH_FIRST, lzo_pkg::PH_TOK0, lzo_pkg::PH_TOK1,
				lzo_pkg::PH_TOK2: begin
					if (phase_q == lzo_pkg::PH_FIRST && in_byte > 8'd17) begin
						lit_n = LB'(in_byte - 8'd17);
						ph_n = (in_byte < 8'd21) ? lzo_pkg::PH_PIGGY : lzo_pkg::PH_LITRUN;
					end else if (in_byte >= 8'd64) begin
						ph_n = lzo_pkg::PH_M2B;
					end else if (in_byte >= 8'd32) begin
						acc_n = (in_byte[4:0] != '0) ? LB'(in_byte[4:0]) + LB'(2) : '0;
						ph_n = (in_byte[4:0] != '0) ? lzo_pkg::PH_LO : lzo_pkg::PH_M3X;
					end else if (in_byte >= 8'd16) begin
						acc_n = (in_byte[2:0] != '0) ? LB'(in_byte[2:0]) + LB'(2) : '0;
						ph_n = (in_byte[2:0] != '0) ? lzo_pkg::PH_LO : lzo_pkg::PH_M4X;
					end else if (phase_q == lzo_pkg::PH_TOK1) begin
						ph_n = lzo_pkg::PH_M1FAR;
					end else if (phase_q == lzo_pkg::PH_TOK2) begin
						ph_n = lzo_pkg::PH_M1NEAR;
					end else if (in_byte == 8'd0) begin
						acc_n = '0;
						ph_n = lzo_pkg::PH_LITX;
					end else begin
						lit_n = LB'(in_byte) + LB'(3);
						ph_n = lzo_pkg::PH_LITRUN;
					end
				end
				lzo_pkg::PH_LITX, lzo_pkg::PH_M3X, lzo_pkg::PH_M4X: begin
					if (in_byte == 8'd0) begin
						if (accp > {1'b0, lzo_pkg::LenMax}) ovf = 1'b1;
						else acc_n = accp[LB-1:0];
					end else if (total > {1'b0, lzo_pkg::LenMax}) begin
						ovf = 1'b1;
					end else if (phase_q == lzo_pkg::PH_LITX) begin
						lit_n = total[LB-1:0];
						ph_n = lzo_pkg::PH_LITRUN;
					end else begin
						acc_n = total[LB-1:0];
						ph_n = lzo_pkg::PH_LO;
					end
				end
				lzo_pkg::PH_LITRUN, lzo_pkg::PH_PIGGY: begin
					emit = 1'b1;
					lit_n = lit_q - LB'(1);
					if (lit_q == LB'(1))
						ph_n = (phase_q == lzo_pkg::PH_LITRUN) ? lzo_pkg::PH_TOK1 : lzo_pkg::PH_TOK2;
				end
				lzo_pkg::PH_LO: ph_n = lzo_pkg::PH_HI;
				lzo_pkg::PH_HI: begin
					if (tok_q >= 8'd32) begin
						dist_n = WB'(off + 17'd1);
						copy_n = acc_q;
						lit_n = LB'(b1_q[1:0]);
						ph_n = lzo_pkg::PH_DRAIN;
					end else if (d == '0) begin
						eof = 1'b1;
					end else begin
						dist_n = WB'(d + 17'h4000);
						copy_n = acc_q;
						lit_n = LB'(b1_q[1:0]);
						ph_n = lzo_pkg::PH_DRAIN;
					end
				end
				lzo_pkg::PH_M2B, lzo_pkg::PH_M1FAR, lzo_pkg::PH_M1NEAR: begin
					lit_n = LB'(b1_q[1:0]);
					ph_n = lzo_pkg::PH_DRAIN;
					if (phase_q == lzo_pkg::PH_M2B) begin
						dist_n = WB'(17'd1 + 17'(tok_q[4:2]) + 17'({in_byte, 3'd0}));
						copy_n = LB'(tok_q[7:5]) + LB'(1);
					end else if (phase_q == lzo_pkg::PH_M1FAR) begin
						dist_n = WB'(17'h801 + 17'(tok_q[7:2]) + 17'({in_byte, 2'd0}));
						copy_n = LB'(3);
					end else begin
						dist_n = WB'(17'd1 + 17'(tok_q[7:2]) + 17'({in_byte, 2'd0}));
						copy_n = LB'(2);
					end
				end
				default: ph_n = lzo_pkg::PH_TOK0;
			endcase
			if (ovf) begin
				fin_n = 1'b1;
				copy_n = '0;
				emit = 1'b0;
				st = lzo_pkg::ST_OVF;
			end else if (eof) begin
				fin_n = 1'b1;
				st = last_byte ? lzo_pkg::ST_OK : lzo_pkg::ST_TRAIL;
			end else if (last_byte) begin
				fin_n = 1'b1;
				copy_n = '0;
				st = lzo_pkg::ST_NOEND;
			end
		end
		job.copy = mode && !refuse;
		job.rd_addr = wpos_q - dist_q;
		job.emit = emit;
		job.lit = in_byte;
		job.pending = !fin_n && copy_n != '0;
		job.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzo_pkg::PH_FIRST;
			tok_q <= '0;
			b1_q <= '0;
			acc_q <= '0;
			lit_q <= '0;
			copy_q <= '0;
			dist_q <= '0;
			fin_q <= 1'b0;
			wpos_q <= '0;
		end else if (valid && ready) begin
			phase_q <= ph_n;
			acc_q <= acc_n;
			lit_q <= lit_n;
			copy_q <= copy_n;
			dist_q <= dist_n;
			fin_q <= fin_n;
			if (emit) wpos_q <= wpos_q + WB'(1);
			if (!refuse && !mode) begin
				b1_q <= in_byte;
				if (phase_q == lzo_pkg::PH_FIRST || phase_q == lzo_pkg::PH_TOK0 ||
					phase_q == lzo_pkg::PH_TOK1 || phase_q == lzo_pkg::PH_TOK2)
					tok_q <= in_byte;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lzo_back.sv
// Byte writer: reads and writes history and produces result transfers.
`timescale 1ns / 1ps
`default_nettype none
module lzo_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire lzo_pkg::job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic copy_pending,
	output logic [2:0] status,
	output logic [31:0] total_out
);
	localparam int WB = lzo_pkg::WindowBits;

	logic v_s1, v_s2, take;
	lzo_pkg::job_t j_s1;
	logic [WB-1:0] wpos_q;
	logic [7:0] rdata, byte_s1;
	logic fwd_s1;
	logic [31:0] cnt_q;
	logic [7:0] last_q;
	logic we;

	assign job_ready = !v_s2 || res_ready || !v_s1;
	assign take = job_valid && job_ready;
	assign res_valid = v_s2;

	lzo_ram #(.Width(8), .Depth(1 << WB)) u_hist (
		.clk(clk), .we(we), .waddr(wpos_q), .wdata(byte_s1),
		.re(take), .raddr(job.rd_addr), .rdata(rdata)
	);

	always_comb begin
		byte_s1 = j_s1.copy ? (fwd_s1 ? last_q : rdata) : j_s1.lit;
		we = v_s1 && j_s1.emit && (!v_s2 || res_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wpos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (!v_s2 || res_ready) begin
				v_s2 <= v_s1;
				if (v_s1 && j_s1.emit) begin
					wpos_q <= wpos_q + WB'(1);
					cnt_q <= cnt_q + 32'd1;
				end
			end
			if (take) v_s1 <= 1'b1;
			else if (!v_s2 || res_ready) v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			j_s1 <= job;
			fwd_s1 <= v_s1 && j_s1.emit && job.rd_addr == wpos_q;
		end
		if (v_s1 && j_s1.emit && (!v_s2 || res_ready)) last_q <= byte_s1;
		if (v_s1 && (!v_s2 || res_ready)) begin
			out_byte <= j_s1.emit ? byte_s1 : 8'd0;
			out_valid <= j_s1.emit;
			copy_pending <= j_s1.pending;
			status <= j_s1.status;
			total_out <= j_s1.emit ? cnt_q + 32'd1 : cnt_q;
		end
	end
endmodule
`default_nettype wire
